[hdl/rsct_pkg.sv]
// Package for the ranked score table: field widths, request and status codes,
// cell commands and default sizes.
// No dependencies; every other file of the block imports it.
package rsct_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int KEY_BYTES_DEF = 8;

    localparam int REQ_W    = 3;
    localparam int KEY_FW   = 64;
    localparam int SCORE_W  = 64;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;

    // Longest run a top request may return.
    localparam int LIST_MAX = 64;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 144;

    localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RANK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SCORE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TOP    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic [1:0] op;      // hold, close a gap, or open one for a new entry
        logic       sel_hit; // read port follows the key match, else the index
    } t_cell_ctl;

endpackage

[hdl/ranked_score_table.sv]
// Ranked score table top level: request sequencer, entry count and result
// register around the rsct_chain cell row. Depends on rsct_pkg and rsct_chain.
//
//  Port group   Role     Beat payload
//  s_axis       request  req_type, player_key, new_score, top_count
//  m_axis       result   status, position, entry_key, entry_score; tlast = last
//
// One request is taken at a time. Look-up follows the input beat, then execution.
// A query, remove or in-place update ends there; an update that moves an entry
// runs a removal pass, then an insertion pass through the cell chain, one that
// adds an entry runs the insertion pass only, and a top request returns one beat per listed entry.
// Reset clears the entry count and the sequencer; cell contents are not cleared.
// A stalled result beat holds the sequencer in the state that produces the next
// beat, while the result register keeps the stalled beat.
module ranked_score_table #(
    parameter int DEPTH     = rsct_pkg::DEPTH_DEF,
    parameter int KEY_BYTES = rsct_pkg::KEY_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // req_type[2:0], player_key[66:3], new_score[130:67], top_count[137:131]
    input  logic [rsct_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // status[1:0], position[8:2], entry_key[72:9], entry_score[136:73]
    output logic [rsct_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);
    import rsct_pkg::*;

    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_LIST   = 3'd4;

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic [REQ_W-1:0]          r_req;
    logic [KEY_W-1:0]          r_key;
    logic signed [SCORE_W-1:0] r_score;
    logic [COUNT_W-1:0]        r_want;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_found;
    logic [IDX_W-1:0]          r_idx;
    logic signed [SCORE_W-1:0] r_hit_score;
    logic [POS_W-1:0]          r_pos;
    logic [POS_W-1:0]          n_pos;
    logic [POS_W-1:0]          r_n;
    logic [POS_W-1:0]          n_n;

    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [STATUS_W-1:0]       r_out_status;
    logic [STATUS_W-1:0]       n_out_status;
    logic [POS_W-1:0]          r_out_pos;
    logic [POS_W-1:0]          n_out_pos;
    logic [KEY_FW-1:0]         r_out_key;
    logic [KEY_FW-1:0]         n_out_key;
    logic [SCORE_W-1:0]        r_out_score;
    logic [SCORE_W-1:0]        n_out_score;
    logic                      r_out_last;
    logic                      n_out_last;

    t_cell_ctl                 w_ctl;
    logic [IDX_W-1:0]          w_chain_idx;
    logic                      w_found;
    logic [IDX_W-1:0]          w_hit_idx;
    logic [KEY_W-1:0]          w_rd_key;
    logic signed [SCORE_W-1:0] w_rd_score;
    logic                      w_in_beat;
    logic                      w_out_free;
    logic [POS_W-1:0]          w_rank;
    logic [CMP_W-1:0]          w_want_c;
    logic [CMP_W-1:0]          w_cnt_c;
    logic [CMP_W-1:0]          w_n1;
    logic [POS_W-1:0]          w_n;
    logic [POS_W-1:0]          w_pos1;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_beat       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    assign w_chain_idx = (r_state == S_LIST) ? IDX_W'(r_pos) : r_idx;
    assign w_rank      = POS_W'({1'b0, r_idx} + (IDX_W + 1)'(1));
    assign w_want_c    = CMP_W'(r_want);
    assign w_cnt_c     = CMP_W'(r_count);
    assign w_n1        = (w_want_c < w_cnt_c) ? w_want_c : w_cnt_c;
    assign w_n         = (w_n1 > CMP_W'(LIST_MAX)) ? POS_W'(LIST_MAX) : POS_W'(w_n1);
    assign w_pos1      = r_pos + POS_W'(1);

    rsct_chain #(
        .DEPTH (DEPTH),
        .KEY_W (KEY_W),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_idx      (w_chain_idx),
        .i_count    (r_count),
        .i_key      (r_key),
        .i_score    (r_score),
        .o_found    (w_found),
        .o_hit_idx  (w_hit_idx),
        .o_rd_key   (w_rd_key),
        .o_rd_score (w_rd_score)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_n          = r_n;
        w_ctl.op     = OP_HOLD;
        w_ctl.sel_hit = (r_state == S_LOOK);
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_key    = r_out_key;
        n_out_score  = r_out_score;
        n_out_last   = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_out_pos   = '0;
                    n_out_key   = KEY_FW'(r_key);
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                    case (r_req)
                        REQ_UPDATE: begin
                            n_out_score = r_score;
                            if (r_found && (r_hit_score == r_score)) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_OK;
                            end else if (r_found) begin
                                // Close the gap now, reinsert at the new place next.
                                w_ctl.op = OP_REMOVE;
                                n_count  = r_count - CNT_W'(1);
                                n_state  = S_INSERT;
                            end else if (r_count == CNT_W'(DEPTH)) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_FULL;
                            end else begin
                                n_state = S_INSERT;
                            end
                        end
                        REQ_REMOVE: begin
                            n_out_valid = 1'b1;
                            if (r_found) begin
                                w_ctl.op     = OP_REMOVE;
                                n_count      = r_count - CNT_W'(1);
                                n_out_status = ST_OK;
                                n_out_score  = r_hit_score;
                            end else begin
                                n_out_status = ST_NOT_FOUND;
                                n_out_score  = '0;
                            end
                        end
                        REQ_RANK, REQ_SCORE: begin
                            n_out_valid = 1'b1;
                            if (r_found) begin
                                n_out_status = ST_OK;
                                n_out_score  = r_hit_score;
                                n_out_pos    = (r_req == REQ_RANK) ? w_rank : '0;
                            end else begin
                                n_out_status = ST_NOT_FOUND;
                                n_out_score  = '0;
                            end
                        end
                        REQ_TOP: begin
                            if (w_n == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_NOT_FOUND;
                                n_out_key    = '0;
                                n_out_score  = '0;
                            end else begin
                                n_n     = w_n;
                                n_pos   = '0;
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INSERT: begin
                if (w_out_free) begin
                    w_ctl.op     = OP_INSERT;
                    n_count      = r_count + CNT_W'(1);
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_pos    = '0;
                    n_out_key    = KEY_FW'(r_key);
                    n_out_score  = r_score;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_LIST: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_pos    = w_pos1;
                    n_out_key    = KEY_FW'(w_rd_key);
                    n_out_score  = w_rd_score;
                    n_out_last   = (w_pos1 == r_n);
                    n_pos        = w_pos1;
                    if (w_pos1 == r_n) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_req   <= i_s_axis_tdata[2:0];
            r_key   <= i_s_axis_tdata[3 +: KEY_W];
            r_score <= i_s_axis_tdata[130:67];
            r_want  <= i_s_axis_tdata[137:131];
        end
        if (r_state == S_LOOK) begin
            r_found     <= w_found;
            r_idx       <= w_hit_idx;
            r_hit_score <= w_rd_score;
        end
        r_pos        <= n_pos;
        r_n          <= n_n;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_key    <= n_out_key;
        r_out_score  <= n_out_score;
        r_out_last   <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {7'd0, r_out_score, r_out_key, r_out_pos, r_out_status};

endmodule

[hdl/rsct_cell.sv]
// One cell of the sorted chain: holds a single (key, score) entry and trades it
// with its neighbors on remove and insert commands. Depends on rsct_pkg.
module rsct_cell #(
    parameter int IDX_W = 6,
    parameter int CNT_W = 7,
    parameter int KEY_W = 64
) (
    input  logic                                i_clk,
    input  rsct_pkg::t_cell_ctl                 i_ctl,
    input  logic [IDX_W-1:0]                    i_cell_idx,
    input  logic [IDX_W-1:0]                    i_idx,
    input  logic [CNT_W-1:0]                    i_count,
    input  logic [KEY_W-1:0]                    i_key,
    input  logic signed [rsct_pkg::SCORE_W-1:0] i_score,
    input  logic [KEY_W-1:0]                    i_left_key,
    input  logic signed [rsct_pkg::SCORE_W-1:0] i_left_score,
    input  logic                                i_left_ahead,
    input  logic [KEY_W-1:0]                    i_right_key,
    input  logic signed [rsct_pkg::SCORE_W-1:0] i_right_score,
    output logic [KEY_W-1:0]                    o_key,
    output logic signed [rsct_pkg::SCORE_W-1:0] o_score,
    output logic                                o_ahead,
    output logic                                o_match,
    output logic [KEY_W-1:0]                    o_rd_key,
    output logic signed [rsct_pkg::SCORE_W-1:0] o_rd_score
);
    import rsct_pkg::*;

    logic [KEY_W-1:0]          r_key;
    logic [KEY_W-1:0]          n_key;
    logic signed [SCORE_W-1:0] r_score;
    logic signed [SCORE_W-1:0] n_score;
    logic                      w_occupied;
    logic                      w_better;
    logic                      w_sel;

    assign w_occupied = CNT_W'(i_cell_idx) < i_count;
    assign w_better   = (r_score > i_score) || ((r_score == i_score) && (r_key < i_key));
    assign o_ahead    = w_occupied && w_better;
    assign o_match    = w_occupied && (r_key == i_key);
    assign w_sel      = i_ctl.sel_hit ? o_match : (i_cell_idx == i_idx);
    assign o_rd_key   = w_sel ? r_key : '0;
    assign o_rd_score = w_sel ? r_score : '0;
    assign o_key      = r_key;
    assign o_score    = r_score;

    always_comb begin
        n_key   = r_key;
        n_score = r_score;
        case (i_ctl.op)
            OP_REMOVE: begin
                if (i_cell_idx >= i_idx) begin
                    n_key   = i_right_key;
                    n_score = i_right_score;
                end
            end
            OP_INSERT: begin
                // The first cell that does not rank ahead takes the new entry;
                // every cell after it takes its left neighbor's entry.
                if (!o_ahead) begin
                    if (i_left_ahead) begin
                        n_key   = i_key;
                        n_score = i_score;
                    end else begin
                        n_key   = i_left_key;
                        n_score = i_left_score;
                    end
                end
            end
            default: begin
                n_key   = r_key;
                n_score = r_score;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_score <= n_score;
    end

endmodule

[hdl/rsct_chain.sv]
// Row of rsct_cell instances wired to their neighbors, with the shared read
// port and the key match reduction. Depends on rsct_pkg and rsct_cell.
module rsct_chain #(
    parameter int DEPTH = rsct_pkg::DEPTH_DEF,
    parameter int KEY_W = 8 * rsct_pkg::KEY_BYTES_DEF,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                i_clk,
    input  rsct_pkg::t_cell_ctl                 i_ctl,
    input  logic [IDX_W-1:0]                    i_idx,
    input  logic [CNT_W-1:0]                    i_count,
    input  logic [KEY_W-1:0]                    i_key,
    input  logic signed [rsct_pkg::SCORE_W-1:0] i_score,
    output logic                                o_found,
    output logic [IDX_W-1:0]                    o_hit_idx,
    output logic [KEY_W-1:0]                    o_rd_key,
    output logic signed [rsct_pkg::SCORE_W-1:0] o_rd_score
);
    import rsct_pkg::*;

    logic [KEY_W-1:0]          w_key      [DEPTH];
    logic signed [SCORE_W-1:0] w_score    [DEPTH];
    logic [KEY_W-1:0]          w_rd_key   [DEPTH];
    logic signed [SCORE_W-1:0] w_rd_score [DEPTH];
    logic [DEPTH-1:0]          w_ahead;
    logic [DEPTH-1:0]          w_match;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0]          w_lkey;
        logic signed [SCORE_W-1:0] w_lscore;
        logic                      w_lahead;
        logic [KEY_W-1:0]          w_rkey;
        logic signed [SCORE_W-1:0] w_rscore;

        if (g == 0) begin : g_head
            assign w_lkey   = '0;
            assign w_lscore = '0;
            assign w_lahead = 1'b1;
        end else begin : g_mid
            assign w_lkey   = w_key[g-1];
            assign w_lscore = w_score[g-1];
            assign w_lahead = w_ahead[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_rkey   = w_key[g];
            assign w_rscore = w_score[g];
        end else begin : g_body
            assign w_rkey   = w_key[g+1];
            assign w_rscore = w_score[g+1];
        end

        rsct_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .KEY_W (KEY_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (i_ctl),
            .i_cell_idx    (IDX_W'(g)),
            .i_idx         (i_idx),
            .i_count       (i_count),
            .i_key         (i_key),
            .i_score       (i_score),
            .i_left_key    (w_lkey),
            .i_left_score  (w_lscore),
            .i_left_ahead  (w_lahead),
            .i_right_key   (w_rkey),
            .i_right_score (w_rscore),
            .o_key         (w_key[g]),
            .o_score       (w_score[g]),
            .o_ahead       (w_ahead[g]),
            .o_match       (w_match[g]),
            .o_rd_key      (w_rd_key[g]),
            .o_rd_score    (w_rd_score[g])
        );
    end

    // At most one cell is selected, so the read port is a plain OR of all cells.
    always_comb begin
        o_rd_key   = '0;
        o_rd_score = '0;
        o_hit_idx  = '0;
        for (int k = 0; k < DEPTH; k++) begin
            o_rd_key   = o_rd_key | w_rd_key[k];
            o_rd_score = o_rd_score | w_rd_score[k];
            o_hit_idx  = o_hit_idx | (w_match[k] ? IDX_W'(k) : '0);
        end
    end

    assign o_found = |w_match;

endmodule

[hdl/rsct_checker.sv]
// Port-level checks for the ranked score table, bound to the top level.
// Depends on rsct_pkg and ranked_score_table.
module rsct_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            i_s_axis_tready,
    input logic                            i_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [rsct_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    input logic                            i_m_axis_tlast
);
    import rsct_pkg::*;

    logic w_in_beat;
    assign w_in_beat = i_s_axis_tvalid && i_s_axis_tready;

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tlast))
        else $error("result beat changed while stalled");

    // Requests are handled one at a time.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !i_s_axis_tready)
        else $error("request accepted while another is in work");

    // Error results are single beats with no position.
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && (i_m_axis_tdata[1:0] != ST_OK) |->
            i_m_axis_tlast && (i_m_axis_tdata[8:2] == '0))
        else $error("error result is not a final beat at position zero");

    // A listed entry carries a nonzero rank.
    a_top_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tlast && (i_m_axis_tdata[1:0] == ST_OK) |->
            (i_m_axis_tdata[8:2] != '0))
        else $error("non-final beat without a rank");

    // Nothing leaves the block right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("result beat right after reset");

endmodule

bind ranked_score_table rsct_checker u_rsct_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tlast  (o_m_axis_tlast)
);

[sim/tb_top.sv]
// Self-checking bench for ranked_score_table: a queue-fed request driver, a result
// monitor and an in-bench model of the sorted table that predicts every result beat.
// Depends on rsct_pkg and the ranked_score_table RTL.
module tb_top;
    import rsct_pkg::*;

    localparam int TABLE_DEPTH  = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 420;
    localparam int POOL_SIZE    = 72;
    localparam int ROUND_LEN    = 210;
    localparam int FILL_LEN     = 130;
    localparam int MIXED_LEN    = 40;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int REPORT_MAX   = 100;

    // Request codes above REQ_TOP are not decoded by the block.
    localparam logic [REQ_W-1:0] REQ_RSVD_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD_HI = 3'd7;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    // "ann", "bob" packed big-endian and zero padded.
    localparam logic [KEY_FW-1:0] KEY_ANN  = 64'h616E_6E00_0000_0000;
    localparam logic [KEY_FW-1:0] KEY_BOB  = 64'h626F_6200_0000_0000;
    localparam logic [KEY_FW-1:0] KEY_ZERO = '0;
    localparam logic [KEY_FW-1:0] KEY_ONES = '1;

    typedef struct {
        logic [REQ_W-1:0]          kind;
        logic [KEY_FW-1:0]         key;
        logic signed [SCORE_W-1:0] score;
        logic [COUNT_W-1:0]        count;
    } t_request;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic [POS_W-1:0]          position;
        logic [KEY_FW-1:0]         key;
        logic signed [SCORE_W-1:0] score;
        logic                      is_last;
    } t_result;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    wire [STATUS_W-1:0] got_status   = o_m_axis_tdata[STATUS_W-1:0];
    wire [POS_W-1:0]    got_position = o_m_axis_tdata[STATUS_W +: POS_W];
    wire [KEY_FW-1:0]   got_key      = o_m_axis_tdata[STATUS_W+POS_W +: KEY_FW];
    wire [SCORE_W-1:0]  got_score    = o_m_axis_tdata[STATUS_W+POS_W+KEY_FW +: SCORE_W];

    // Model of the table contents, best rank first.
    logic [KEY_FW-1:0]         board_key[TABLE_DEPTH];
    logic signed [SCORE_W-1:0] board_score[TABLE_DEPTH];
    int                        board_count;

    t_request request_queue[$];
    t_result  expected_beats[$];
    t_request held_request;
    logic [KEY_FW-1:0] key_pool[POOL_SIZE];
    int fill_ptr;

    int  send_wait;
    int  recv_wait;
    bit  send_calm;
    bit  recv_calm;
    int  cycle_count;
    int  fail_count;
    int  requests_total;
    int  requests_taken;
    int  beats_checked;
    int  top_requests;
    int  full_refusals;
    int  missed_lookups;
    int  peak_fill;

    ranked_score_table u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Higher score wins; on equal scores the smaller key ranks first.
    function automatic bit ranks_ahead(input logic signed [SCORE_W-1:0] sa,
                                       input logic [KEY_FW-1:0] ka,
                                       input logic signed [SCORE_W-1:0] sb,
                                       input logic [KEY_FW-1:0] kb);
        if (sa != sb) return sa > sb;
        return ka < kb;
    endfunction

    function automatic int board_find(input logic [KEY_FW-1:0] key);
        int i;
        for (i = 0; i < board_count; i++)
            if (board_key[i] == key) return i;
        return board_count;
    endfunction

    function automatic void board_drop(input int idx);
        int i;
        for (i = idx; i < board_count - 1; i++) begin
            board_key[i]   = board_key[i+1];
            board_score[i] = board_score[i+1];
        end
        board_count--;
    endfunction

    function automatic void board_put(input logic [KEY_FW-1:0] key,
                                      input logic signed [SCORE_W-1:0] score);
        int p;
        int q;
        p = 0;
        while (p < board_count && ranks_ahead(board_score[p], board_key[p], score, key))
            p++;
        for (q = board_count; q > p; q--) begin
            board_key[q]   = board_key[q-1];
            board_score[q] = board_score[q-1];
        end
        board_key[p]   = key;
        board_score[p] = score;
        board_count++;
        if (board_count > peak_fill) peak_fill = board_count;
    endfunction

    // Appends one predicted beat at the tail of the expected list.
    function automatic void expect_beat(input t_result res);
        expected_beats.insert(expected_beats.size(), res);
    endfunction

    // Appends one request at the tail of the pending list.
    function automatic void enqueue_request(input t_request r);
        request_queue.insert(request_queue.size(), r);
    endfunction

    // Applies one accepted request to the model and queues the beats it must produce.
    function automatic void rank_table_apply(input t_request r);
        int      idx;
        int      n;
        int      j;
        bit      found;
        t_result res;
        idx = board_find(r.key);
        found = idx < board_count;
        res.status   = ST_OK;
        res.position = '0;
        res.key      = r.key;
        res.score    = '0;
        res.is_last  = 1'b1;
        case (r.kind)
            REQ_UPDATE: begin
                res.score = r.score;
                if (found) begin
                    if (board_score[idx] != r.score) begin
                        board_drop(idx);
                        board_put(r.key, r.score);
                    end
                end else if (board_count >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                    full_refusals++;
                end else begin
                    board_put(r.key, r.score);
                end
                expect_beat(res);
            end
            REQ_REMOVE: begin
                if (found) begin
                    res.score = board_score[idx];
                    board_drop(idx);
                end else begin
                    res.status = ST_NOT_FOUND;
                end
                expect_beat(res);
            end
            REQ_RANK, REQ_SCORE: begin
                if (found) begin
                    res.score = board_score[idx];
                    if (r.kind == REQ_RANK) res.position = POS_W'(idx + 1);
                end else begin
                    res.status = ST_NOT_FOUND;
                    missed_lookups++;
                end
                expect_beat(res);
            end
            REQ_TOP: begin
                top_requests++;
                n = int'(r.count);
                if (n > board_count) n = board_count;
                if (n > LIST_MAX) n = LIST_MAX;
                if (n == 0) begin
                    res.status = ST_NOT_FOUND;
                    res.key    = '0;
                    expect_beat(res);
                end
                for (j = 0; j < n; j++) begin
                    res.position = POS_W'(j + 1);
                    res.key      = board_key[j];
                    res.score    = board_score[j];
                    res.is_last  = (j == n - 1);
                    expect_beat(res);
                end
            end
            default: ;  // not decoded: no beat, no change
        endcase
    endfunction

    function automatic void queue_request(input logic [REQ_W-1:0] kind,
                                          input logic [KEY_FW-1:0] key,
                                          input logic signed [SCORE_W-1:0] score,
                                          input logic [COUNT_W-1:0] count);
        t_request r;
        r.kind  = kind;
        r.key   = key;
        r.score = score;
        r.count = count;
        enqueue_request(r);
    endfunction

    // While filling, most updates walk the key pool so that the table reaches full.
    function automatic logic [KEY_FW-1:0] pick_key(input bit walk);
        logic [KEY_FW-1:0] k;
        if (walk && $urandom_range(0, 3) != 0) begin
            k = key_pool[fill_ptr];
            fill_ptr = (fill_ptr + 1) % POOL_SIZE;
        end else if ($urandom_range(0, 9) == 0) begin
            k = {$urandom, $urandom};
        end else begin
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return k;
    endfunction

    // A narrow band of scores makes ties and same-score updates common.
    function automatic logic signed [SCORE_W-1:0] pick_score();
        logic signed [SCORE_W-1:0] s;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            s = SCORE_W'($urandom_range(0, 6));
            s = s - SCORE_W'(3);
        end else if (roll < 55) begin
            case ($urandom_range(0, 3))
                0:       s = SCORE_MIN;
                1:       s = SCORE_MAX;
                2:       s = '1;
                default: s = '0;
            endcase
        end else begin
            s = {$urandom, $urandom};
        end
        return s;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return COUNT_W'(LIST_MAX);
        if (roll < 50) return COUNT_W'($urandom_range(0, 3));
        return COUNT_W'($urandom_range(0, LIST_MAX));
    endfunction

    // Each round fills the table, mixes all requests, then drains it.
    function automatic t_request random_request(input int pos);
        t_request r;
        int roll;
        int t_upd;
        int t_rem;
        int t_rank;
        int t_score;
        int t_top;
        if (pos < FILL_LEN) begin
            t_upd = 70; t_rem = 75; t_rank = 83; t_score = 90; t_top = 97;
        end else if (pos < FILL_LEN + MIXED_LEN) begin
            t_upd = 35; t_rem = 55; t_rank = 70; t_score = 82; t_top = 97;
        end else begin
            t_upd = 15; t_rem = 70; t_rank = 80; t_score = 88; t_top = 98;
        end
        roll = $urandom_range(0, 99);
        if (roll < t_upd)        r.kind = REQ_UPDATE;
        else if (roll < t_rem)   r.kind = REQ_REMOVE;
        else if (roll < t_rank)  r.kind = REQ_RANK;
        else if (roll < t_score) r.kind = REQ_SCORE;
        else if (roll < t_top)   r.kind = REQ_TOP;
        else                     r.kind = REQ_RSVD_LO + REQ_W'($urandom_range(0, 2));
        r.key   = pick_key(r.kind == REQ_UPDATE && pos < FILL_LEN);
        r.score = pick_score();
        r.count = pick_count();
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < REPORT_MAX)
            $display("beat %0d: %s is %h, expected %h", beats_checked, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : request_driver
        t_request nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            send_wait       <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                rank_table_apply(held_request);
                requests_taken++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_wait > 0) begin
                    send_wait       <= send_wait - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    nxt = request_queue.pop_front();
                    held_request = nxt;
                    i_s_axis_tdata  <= {{(IN_DATA_W-REQ_W-KEY_FW-SCORE_W-COUNT_W){1'b0}},
                                        nxt.count, nxt.score, nxt.key, nxt.kind};
                    i_s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
                    send_wait <= send_calm ? 0 : $urandom_range(0, 18);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        int      stall_next;
        t_result want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            recv_wait       <= 0;
        end else begin
            stall_next = recv_wait;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat, key", got_key, '0);
                end else begin
                    want = expected_beats.pop_front();
                    if (got_status != want.status)
                        report_mismatch("status", got_status, want.status);
                    if (got_position != want.position)
                        report_mismatch("position", got_position, want.position);
                    if (got_key != want.key)
                        report_mismatch("entry key", got_key, want.key);
                    if (got_score != want.score)
                        report_mismatch("entry score", got_score, want.score);
                    if (o_m_axis_tlast != want.is_last)
                        report_mismatch("tlast", o_m_axis_tlast, want.is_last);
                end
                beats_checked++;
                if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
                stall_next = recv_calm ? 0 : $urandom_range(0, 18);
            end
            if (stall_next > 0) begin
                i_m_axis_tready <= 1'b0;
                recv_wait       <= stall_next - 1;
            end else begin
                i_m_axis_tready <= 1'b1;
                recv_wait       <= 0;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d beats still owed",
                     cycle_count, expected_beats.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int i;
        int made;
        int step;
        t_request r;
        board_count = 0;
        fill_ptr    = 0;
        key_pool[0] = KEY_ZERO;
        key_pool[1] = KEY_ONES;
        key_pool[2] = KEY_ANN;
        key_pool[3] = KEY_BOB;
        for (i = 4; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

        // Directed: empty table, extremes, ties, same-score and moving updates.
        queue_request(REQ_TOP, KEY_ZERO, 0, 5);
        queue_request(REQ_RANK, KEY_ANN, 0, 0);
        queue_request(REQ_SCORE, KEY_ANN, 0, 0);
        queue_request(REQ_REMOVE, KEY_ANN, 0, 0);
        queue_request(REQ_UPDATE, KEY_ZERO, SCORE_MIN, 0);
        queue_request(REQ_UPDATE, KEY_ONES, SCORE_MAX, COUNT_W'(LIST_MAX));
        queue_request(REQ_UPDATE, KEY_BOB, 0, 0);
        queue_request(REQ_UPDATE, KEY_ANN, 0, 0);
        queue_request(REQ_UPDATE, KEY_BOB, 0, 0);
        queue_request(REQ_UPDATE, KEY_BOB, 5, 0);
        queue_request(REQ_UPDATE, KEY_ANN, -1, 0);
        queue_request(REQ_RANK, KEY_ANN, 0, 0);
        queue_request(REQ_RANK, KEY_ONES, 0, 0);
        queue_request(REQ_SCORE, KEY_ZERO, 0, 0);
        queue_request(REQ_TOP, KEY_ZERO, 0, COUNT_W'(LIST_MAX));
        queue_request(REQ_TOP, KEY_ONES, SCORE_MAX, 0);
        queue_request(REQ_TOP, KEY_ZERO, 0, 2);
        queue_request(REQ_RSVD_LO, KEY_ONES, SCORE_MAX, '1);
        queue_request(REQ_RSVD_LO + 3'd1, KEY_ANN, SCORE_MIN, 3);
        queue_request(REQ_RSVD_HI, KEY_BOB, -1, COUNT_W'(LIST_MAX));
        queue_request(REQ_REMOVE, KEY_BOB, 0, 0);
        queue_request(REQ_REMOVE, KEY_ZERO, SCORE_MAX, 0);
        queue_request(REQ_TOP, KEY_ZERO, 0, 1);
        queue_request(REQ_SCORE, KEY_BOB, 0, 0);

        // Random rounds; ignored request codes do not count toward RANDOM_ITEMS.
        made = 0;
        step = 0;
        while (made < RANDOM_ITEMS) begin
            r = random_request(step % ROUND_LEN);
            enqueue_request(r);
            if (r.kind <= REQ_TOP) made++;
            step++;
        end
        requests_total = request_queue.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_taken < requests_total || expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d top listings) and checked %0d result beats.",
                 requests_taken, top_requests, beats_checked);
        $display("Table peaked at %0d entries; %0d updates refused as full, %0d lookups missed.",
                 peak_fill, full_refusals, missed_lookups);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/rsct_pkg.sv
hdl/rsct_cell.sv
hdl/rsct_chain.sv
hdl/ranked_score_table.sv
hdl/rsct_checker.sv
sim/tb_top.sv
